>>> sv/sip24_pkg.sv
// Shared types, constants and round functions of the SipHash-2-4 engine.
package sip24_pkg;

   localparam int unsigned WORD_WIDTH  = 64;
   localparam int unsigned TAIL_WIDTH  = 3;
   localparam int unsigned TAG_WIDTH   = 8;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WORD_WIDTH-1:0] INIT_C0   = 64'h736f6d6570736575;
   localparam logic [WORD_WIDTH-1:0] INIT_C1   = 64'h646f72616e646f6d;
   localparam logic [WORD_WIDTH-1:0] INIT_C2   = 64'h6c7967656e657261;
   localparam logic [WORD_WIDTH-1:0] INIT_C3   = 64'h7465646279746573;
   localparam logic [WORD_WIDTH-1:0] FINAL_XOR = 64'h00000000000000ff;

   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [3:0][WORD_WIDTH-1:0] lanes_type;

   typedef struct packed {
      word_type block;
      logic     first;
      logic     last;
   } entry_type;

   function automatic word_type rotl(input word_type x, input int unsigned r);
      return (x << r) | (x >> (WORD_WIDTH - r));
   endfunction

   function automatic lanes_type sip_round(input lanes_type v);
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      a = v[0];
      b = v[1];
      c = v[2];
      d = v[3];
      a = a + b;  b = rotl(b, 13);
      b = b ^ a;  a = rotl(a, 32);
      c = c + d;  d = rotl(d, 16);
      d = d ^ c;
      a = a + d;  d = rotl(d, 21);
      d = d ^ a;
      c = c + b;  b = rotl(b, 17);
      b = b ^ c;  c = rotl(c, 32);
      return {d, c, b, a};
   endfunction

   function automatic lanes_type double_round(input lanes_type v);
      return sip_round(sip_round(v));
   endfunction

   function automatic lanes_type init_lanes(input word_type k0, input word_type k1);
      return {k1 ^ INIT_C3, k0 ^ INIT_C2, k1 ^ INIT_C1, k0 ^ INIT_C0};
   endfunction

endpackage

>>> sv/sip24_front.sv
// Front end: accepts message words, masks the tail and merges the length tag.
module sip24_front
   import sip24_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  word_type              message_word,
   input  logic [TAIL_WIDTH-1:0] tail_bytes,
   input  logic                  last,
   output entry_type             entry
);

   logic                 in_msg_ff;
   logic                 in_msg_in;
   logic [TAG_WIDTH-1:0] len_ff;
   logic [TAG_WIDTH-1:0] len_in;
   logic [TAG_WIDTH-1:0] len_base;
   logic [TAG_WIDTH-1:0] tag;
   word_type             mask;

   always_comb begin
      len_base = in_msg_ff ? len_ff : '0;
      tag      = len_base + TAG_WIDTH'(tail_bytes);
      mask     = (word_type'(1) << {tail_bytes, 3'b000}) - word_type'(1);
      entry.first = !in_msg_ff;
      entry.last  = last;
      if (last) begin
         entry.block = (message_word & mask) | {tag, {(WORD_WIDTH-TAG_WIDTH){1'b0}}};
         len_in      = tag;
         in_msg_in   = 1'b0;
      end else begin
         entry.block = message_word;
         len_in      = len_base + TAG_WIDTH'(8);
         in_msg_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         len_ff    <= '0;
      end else if (accept) begin
         in_msg_ff <= in_msg_in;
         len_ff    <= len_in;
      end
   end

endmodule

>>> sv/sip24_queue.sv
// Short queue of classified beats between the front end and the round engine.
module sip24_queue
   import sip24_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output entry_type rd_data,
   output logic      empty
);

   entry_type             slots_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff;
   logic [QCNT_WIDTH-1:0] count_ff;

   assign full    = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (rd_en && !wr_en) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> sv/sip24_back.sv
// Round engine: compression, finalization and the result register.
module sip24_back
   import sip24_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  word_type  key_low,
   input  word_type  key_high,
   input  entry_type entry,
   input  logic      entry_empty,
   output logic      entry_pop,
   output logic      empty,
   input  logic      pop,
   output word_type  hash_value
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FIN_A,
      ST_FIN_B
   } state_type;

   state_type state_ff;
   state_type state_in;
   lanes_type lanes_ff;
   lanes_type lanes_in;
   lanes_type base;
   lanes_type absorbed;
   lanes_type fin_b;
   logic      out_valid_ff;
   logic      out_valid_in;
   word_type  hash_ff;
   word_type  hash_in;
   logic      slot_free;

   assign slot_free  = !out_valid_ff || pop;
   assign entry_pop  = (state_ff == ST_RUN) && !entry_empty;
   assign empty      = !out_valid_ff;
   assign hash_value = hash_ff;

   always_comb begin
      base        = entry.first ? init_lanes(key_low, key_high) : lanes_ff;
      base[3]     = base[3] ^ entry.block;
      absorbed    = double_round(base);
      absorbed[0] = absorbed[0] ^ entry.block;
      fin_b       = double_round(lanes_ff);

      state_in     = state_ff;
      lanes_in     = lanes_ff;
      out_valid_in = out_valid_ff && !pop;
      hash_in      = hash_ff;

      case (state_ff)
         ST_RUN: begin
            if (!entry_empty) begin
               lanes_in = absorbed;
               if (entry.last) begin
                  lanes_in[2] = absorbed[2] ^ FINAL_XOR;
                  state_in    = ST_FIN_A;
               end
            end
         end
         ST_FIN_A: begin
            lanes_in = double_round(lanes_ff);
            state_in = ST_FIN_B;
         end
         ST_FIN_B: begin
            if (slot_free) begin
               lanes_in     = fin_b;
               hash_in      = fin_b[0] ^ fin_b[1] ^ fin_b[2] ^ fin_b[3];
               out_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         out_valid_ff <= 1'b0;
         lanes_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         lanes_ff     <= lanes_in;
      end
      hash_ff <= hash_in;
   end

endmodule

>>> sv/siphash_2_4_engine_core.sv
// Top level of the SipHash-2-4 engine: key registers, front end, queue and round engine.
//
//   Channel   Direction  Ports                                          Beat taken when
//   request   in         push, full, req_message_word/tail_bytes/last   push && !full
//   response  out        empty, pop, rsp_hash_value                     pop && !empty
//   csr       in         csr_write_enable, csr_index, csr_write_data    csr_write_enable
//
// A full word is absorbed in a single pass of the round logic, two rounds at once.
// A last word passes the round engine in three steps: compression in ST_RUN, then two
// rounds of finalization in each of ST_FIN_A and ST_FIN_B, then the next message starts.
// Reset clears the key registers, the queue and the engine state.
// A waiting hash stalls the engine only when the next hash is ready to be written.
module siphash_2_4_engine_core
   import sip24_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  word_type              req_message_word,
   input  logic [TAIL_WIDTH-1:0] req_tail_bytes,
   input  logic                  req_last,
   output logic                  empty,
   input  logic                  pop,
   output word_type              rsp_hash_value,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  word_type              csr_write_data
);

   word_type  key_low_ff;
   word_type  key_high_ff;
   logic      accept;
   entry_type front_entry;
   entry_type queue_entry;
   logic      queue_empty;
   logic      queue_pop;

   assign accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_write_data;
            CSR_KEY_HIGH: key_high_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   sip24_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .message_word (req_message_word),
      .tail_bytes   (req_tail_bytes),
      .last         (req_last),
      .entry        (front_entry)
   );

   sip24_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (front_entry),
      .full    (full),
      .rd_en   (queue_pop),
      .rd_data (queue_entry),
      .empty   (queue_empty)
   );

   sip24_back u_back (
      .clock       (clock),
      .reset       (reset),
      .key_low     (key_low_ff),
      .key_high    (key_high_ff),
      .entry       (queue_entry),
      .entry_empty (queue_empty),
      .entry_pop   (queue_pop),
      .empty       (empty),
      .pop         (pop),
      .hash_value  (rsp_hash_value)
   );

endmodule
